// ===== hw/rtl/nearest_neighbor_tour_defines.svh =====
// Assertion macros used by the checker file.
`ifndef NEAREST_NEIGHBOR_TOUR_DEFINES_SVH
`define NEAREST_NEIGHBOR_TOUR_DEFINES_SVH

// Same-cycle implication, switched off while reset is asserted.
`define NNT_ASSERT_IMPLY(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("nnt check failed: same-cycle implication");

// Next-cycle implication, switched off while reset is asserted.
`define NNT_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("nnt check failed: next-cycle implication");

`endif

// ===== hw/rtl/nnt_pkg.sv =====
package nnt_pkg;

    localparam int MAX_NODES   = 32;
    localparam int NODE_BITS   = $clog2(MAX_NODES);
    localparam int COUNT_BITS  = 6;
    localparam int WEIGHT_BITS = 16;
    localparam int TOTAL_BITS  = 22;
    localparam int ADDR_BITS   = 2 * NODE_BITS;
    localparam int MEM_DEPTH   = MAX_NODES * MAX_NODES;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_START = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_wr;
        logic tour_init;
        logic emit_start;
        logic scan_rd;
        logic emit_step;
        logic ret_rd;
        logic emit_ret;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
        logic scan_last;
        logic tour_last;
    } stat_t;

    // Running total saturates at its all-ones value.
    function automatic logic [TOTAL_BITS-1:0] sat_add(
        input logic [TOTAL_BITS-1:0]  total,
        input logic [WEIGHT_BITS-1:0] w
    );
        logic [TOTAL_BITS:0] sum;
        sum = {1'b0, total} + {{(TOTAL_BITS + 1 - WEIGHT_BITS){1'b0}}, w};
        return sum[TOTAL_BITS] ? {TOTAL_BITS{1'b1}} : sum[TOTAL_BITS-1:0];
    endfunction

endpackage

// ===== hw/rtl/nearest_neighbor_tour.sv =====
// Load words give no result; the block is ready again at once. A start word moves the
// control to its start-emit state, which registers the start result once the output is
// free; then one result per tour step follows, and a closing result back at node zero.
// Each step scans all n nodes through the one weight memory read port.
// Synchronous active-low reset clears control and tour state and sets the node count to
// 32; the weight memory is not cleared and holds garbage until written.
module nearest_neighbor_tour (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [nnt_pkg::COUNT_BITS-1:0]  cfg_wr_data,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_op,
    input  logic [nnt_pkg::NODE_BITS-1:0]   s_row_node,
    input  logic [nnt_pkg::NODE_BITS-1:0]   s_col_node,
    input  logic [nnt_pkg::WEIGHT_BITS-1:0] s_weight,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [nnt_pkg::NODE_BITS-1:0]   m_node,
    output logic [nnt_pkg::WEIGHT_BITS-1:0] m_edge_cost,
    output logic [nnt_pkg::TOTAL_BITS-1:0]  m_total_cost,
    output logic                            m_last
);

    nnt_pkg::cmd_t  cmd;
    nnt_pkg::stat_t stat;

    nnt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_op    (s_op),
        .stat    (stat),
        .cmd     (cmd)
    );

    nnt_datapath u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_row_node   (s_row_node),
        .s_col_node   (s_col_node),
        .s_weight     (s_weight),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_node       (m_node),
        .m_edge_cost  (m_edge_cost),
        .m_total_cost (m_total_cost),
        .m_last       (m_last),
        .cmd          (cmd),
        .stat         (stat)
    );

endmodule

// ===== hw/rtl/nnt_ctrl.sv =====
module nnt_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  logic          s_op,
    input  nnt_pkg::stat_t stat,
    output nnt_pkg::cmd_t  cmd
);

    typedef enum logic [6:0] {
        ST_IDLE       = 7'b0000001,
        ST_EMIT_START = 7'b0000010,
        ST_SCAN       = 7'b0000100,
        ST_DRAIN      = 7'b0001000,
        ST_EMIT_STEP  = 7'b0010000,
        ST_RET_READ   = 7'b0100000,
        ST_EMIT_RET   = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;

    always_comb begin
        cmd            = '0;
        cmd.load_wr    = accept && (s_op == nnt_pkg::OP_LOAD);
        cmd.tour_init  = accept && (s_op == nnt_pkg::OP_START);
        cmd.emit_start = (state_reg == ST_EMIT_START) && stat.out_free;
        cmd.scan_rd    = (state_reg == ST_SCAN);
        cmd.emit_step  = (state_reg == ST_EMIT_STEP) && stat.out_free;
        cmd.ret_rd     = (state_reg == ST_RET_READ);
        cmd.emit_ret   = (state_reg == ST_EMIT_RET) && stat.out_free;
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (cmd.tour_init) begin
                    state_next = ST_EMIT_START;
                end
            end
            ST_EMIT_START: begin
                if (stat.out_free) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (stat.scan_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_EMIT_STEP;
            end
            ST_EMIT_STEP: begin
                if (stat.out_free) begin
                    state_next = stat.tour_last ? ST_RET_READ : ST_SCAN;
                end
            end
            ST_RET_READ: begin
                state_next = ST_EMIT_RET;
            end
            ST_EMIT_RET: begin
                if (stat.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== hw/rtl/nnt_datapath.sv =====
module nnt_datapath (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [nnt_pkg::COUNT_BITS-1:0]      cfg_wr_data,
    input  logic [nnt_pkg::NODE_BITS-1:0]       s_row_node,
    input  logic [nnt_pkg::NODE_BITS-1:0]       s_col_node,
    input  logic [nnt_pkg::WEIGHT_BITS-1:0]     s_weight,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [nnt_pkg::NODE_BITS-1:0]       m_node,
    output logic [nnt_pkg::WEIGHT_BITS-1:0]     m_edge_cost,
    output logic [nnt_pkg::TOTAL_BITS-1:0]      m_total_cost,
    output logic                                m_last,
    input  nnt_pkg::cmd_t                       cmd,
    output nnt_pkg::stat_t                      stat
);

    logic [nnt_pkg::WEIGHT_BITS-1:0] mem [nnt_pkg::MEM_DEPTH];
    logic [nnt_pkg::WEIGHT_BITS-1:0] rdata_reg;
    logic [nnt_pkg::ADDR_BITS-1:0]   raddr;
    logic                            rd_en;

    logic [nnt_pkg::COUNT_BITS-1:0]  node_count_reg;
    logic [nnt_pkg::COUNT_BITS-1:0]  n_eff;
    logic [nnt_pkg::COUNT_BITS-1:0]  n_m1;

    logic [nnt_pkg::MAX_NODES-1:0]   visited_reg;
    logic [nnt_pkg::NODE_BITS-1:0]   cur_reg;
    logic [nnt_pkg::TOTAL_BITS-1:0]  total_reg;
    logic [nnt_pkg::TOTAL_BITS-1:0]  step_total;
    logic [nnt_pkg::TOTAL_BITS-1:0]  ret_total;
    logic [nnt_pkg::NODE_BITS-1:0]   cand_reg;
    logic [nnt_pkg::COUNT_BITS-1:0]  step_reg;

    logic                            rd_pend_reg;
    logic                            rd_unv_reg;
    logic [nnt_pkg::NODE_BITS-1:0]   rd_cand_reg;
    logic                            found_reg;
    logic [nnt_pkg::NODE_BITS-1:0]   best_reg;
    logic [nnt_pkg::WEIGHT_BITS-1:0] best_w_reg;
    logic                            cmp_hit;

    logic                            m_valid_reg;
    logic [nnt_pkg::NODE_BITS-1:0]   m_node_reg;
    logic [nnt_pkg::WEIGHT_BITS-1:0] m_edge_reg;
    logic [nnt_pkg::TOTAL_BITS-1:0]  m_total_reg;
    logic                            m_last_reg;
    logic                            out_load;

    // Node count is clamped into the supported range.
    always_comb begin
        if (node_count_reg < nnt_pkg::COUNT_BITS'(2)) begin
            n_eff = nnt_pkg::COUNT_BITS'(2);
        end else if (node_count_reg > nnt_pkg::COUNT_BITS'(nnt_pkg::MAX_NODES)) begin
            n_eff = nnt_pkg::COUNT_BITS'(nnt_pkg::MAX_NODES);
        end else begin
            n_eff = node_count_reg;
        end
    end
    assign n_m1 = n_eff - nnt_pkg::COUNT_BITS'(1);

    assign rd_en = cmd.scan_rd || cmd.ret_rd;
    assign raddr = cmd.ret_rd ? {cur_reg, {nnt_pkg::NODE_BITS{1'b0}}} : {cur_reg, cand_reg};

    always_ff @(posedge aclk) begin
        if (cmd.load_wr) begin
            mem[{s_row_node, s_col_node}] <= s_weight;
        end
        if (rd_en) begin
            rdata_reg <= mem[raddr];
        end
    end

    // One candidate is compared each cycle, on the registered read data of its scan read.
    assign cmp_hit = rd_pend_reg && rd_unv_reg && (!found_reg || (rdata_reg < best_w_reg));

    assign step_total = nnt_pkg::sat_add(total_reg, best_w_reg);
    assign ret_total  = nnt_pkg::sat_add(total_reg, rdata_reg);

    assign out_load = cmd.emit_start || cmd.emit_step || cmd.emit_ret;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            node_count_reg <= nnt_pkg::COUNT_BITS'(nnt_pkg::MAX_NODES);
            visited_reg    <= '0;
            cur_reg        <= '0;
            total_reg      <= '0;
            rd_pend_reg    <= 1'b0;
            found_reg      <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                node_count_reg <= cfg_wr_data;
            end
            rd_pend_reg <= cmd.scan_rd;

            if (cmd.tour_init) begin
                visited_reg <= nnt_pkg::MAX_NODES'(1);
                cur_reg     <= '0;
                total_reg   <= '0;
            end else if (cmd.emit_step) begin
                visited_reg[best_reg] <= 1'b1;
                cur_reg               <= best_reg;
                total_reg             <= step_total;
            end else if (cmd.emit_ret) begin
                cur_reg   <= '0;
                total_reg <= ret_total;
            end

            if (cmd.emit_start || cmd.emit_step) begin
                found_reg <= 1'b0;
            end else if (cmp_hit) begin
                found_reg <= 1'b1;
            end

            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rd_unv_reg  <= !visited_reg[cand_reg];
        rd_cand_reg <= cand_reg;

        if (cmd.emit_start || cmd.emit_step) begin
            cand_reg <= '0;
        end else if (cmd.scan_rd) begin
            cand_reg <= cand_reg + nnt_pkg::NODE_BITS'(1);
        end

        if (cmd.emit_start) begin
            step_reg <= nnt_pkg::COUNT_BITS'(1);
        end else if (cmd.emit_step) begin
            step_reg <= step_reg + nnt_pkg::COUNT_BITS'(1);
        end

        if (cmp_hit) begin
            best_reg   <= rd_cand_reg;
            best_w_reg <= rdata_reg;
        end

        if (cmd.emit_start) begin
            m_node_reg  <= '0;
            m_edge_reg  <= '0;
            m_total_reg <= '0;
            m_last_reg  <= 1'b0;
        end else if (cmd.emit_step) begin
            m_node_reg  <= best_reg;
            m_edge_reg  <= best_w_reg;
            m_total_reg <= step_total;
            m_last_reg  <= 1'b0;
        end else if (cmd.emit_ret) begin
            m_node_reg  <= '0;
            m_edge_reg  <= rdata_reg;
            m_total_reg <= ret_total;
            m_last_reg  <= 1'b1;
        end
    end

    assign stat.out_free  = !m_valid_reg || m_ready;
    assign stat.scan_last = ({1'b0, cand_reg} == n_m1);
    assign stat.tour_last = (step_reg == n_m1);

    assign m_valid      = m_valid_reg;
    assign m_node       = m_node_reg;
    assign m_edge_cost  = m_edge_reg;
    assign m_total_cost = m_total_reg;
    assign m_last       = m_last_reg;

endmodule

// ===== hw/rtl/nnt_checker.sv =====
`include "nearest_neighbor_tour_defines.svh"

module nnt_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_valid,
    input logic                            s_ready,
    input logic                            s_op,
    input logic                            m_valid,
    input logic                            m_ready,
    input logic [nnt_pkg::NODE_BITS-1:0]   m_node,
    input logic [nnt_pkg::WEIGHT_BITS-1:0] m_edge_cost,
    input logic [nnt_pkg::TOTAL_BITS-1:0]  m_total_cost,
    input logic                            m_last
);

    // A stalled result word must hold.
    `NNT_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_node) && $stable(m_edge_cost) && $stable(m_total_cost) && $stable(m_last))

    // While a tour is still running no new input word is taken.
    `NNT_ASSERT_IMPLY(a_busy_in_tour, aclk, aresetn, m_valid && !m_last, !s_ready)

    // A start word closes the input side until its tour is done.
    `NNT_ASSERT_NEXT(a_start_busy, aclk, aresetn, s_valid && s_ready && (s_op == nnt_pkg::OP_START), !s_ready)

    // The closing word returns to node zero; the opening word costs nothing.
    `NNT_ASSERT_IMPLY(a_last_home, aclk, aresetn, m_valid && m_last, m_node == '0)
    `NNT_ASSERT_IMPLY(a_start_zero, aclk, aresetn, m_valid && !m_last && (m_node == '0), (m_edge_cost == '0) && (m_total_cost == '0))

endmodule

bind nearest_neighbor_tour nnt_checker u_nnt_checker (.*);

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

module tb;

    localparam int MAX_NODES   = nnt_pkg::MAX_NODES;
    localparam int NODE_BITS   = nnt_pkg::NODE_BITS;
    localparam int COUNT_BITS  = nnt_pkg::COUNT_BITS;
    localparam int WEIGHT_BITS = nnt_pkg::WEIGHT_BITS;
    localparam int TOTAL_BITS  = nnt_pkg::TOTAL_BITS;

    localparam int HALF_PERIOD   = 5;
    localparam int ITEM_BUDGET   = 480;
    localparam int CALM_TAIL     = 60;
    localparam int BIG_NODES     = 16;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 8;
    localparam int END_CYCLES    = 40;

    localparam logic [WEIGHT_BITS-1:0] WEIGHT_FULL = {WEIGHT_BITS{1'b1}};
    localparam logic [TOTAL_BITS-1:0]  TOTAL_FULL  = {TOTAL_BITS{1'b1}};

    typedef enum int { W_RANDOM, W_TIES, W_EXTREME, W_NEAR_TOP, W_TOP } weight_style_t;

    typedef struct packed {
        logic                   op;
        logic [NODE_BITS-1:0]   row;
        logic [NODE_BITS-1:0]   col;
        logic [WEIGHT_BITS-1:0] weight;
    } graph_word_t;

    typedef struct packed {
        logic [NODE_BITS-1:0]   node;
        logic [WEIGHT_BITS-1:0] edge_cost;
        logic [TOTAL_BITS-1:0]  total_cost;
        logic                   closing;
    } tour_step_t;

    logic                   aclk        = 1'b0;
    logic                   aresetn     = 1'b0;
    logic                   cfg_wr_en   = 1'b0;
    logic [COUNT_BITS-1:0]  cfg_wr_data = '0;
    logic                   s_valid     = 1'b0;
    logic                   s_ready;
    logic                   s_op        = 1'b0;
    logic [NODE_BITS-1:0]   s_row_node  = '0;
    logic [NODE_BITS-1:0]   s_col_node  = '0;
    logic [WEIGHT_BITS-1:0] s_weight    = '0;
    logic                   m_valid;
    logic                   m_ready     = 1'b0;
    logic [NODE_BITS-1:0]   m_node;
    logic [WEIGHT_BITS-1:0] m_edge_cost;
    logic [TOTAL_BITS-1:0]  m_total_cost;
    logic                   m_last;

    graph_word_t words_to_send[$];
    tour_step_t  tour_steps_due[$];
    graph_word_t next_word;
    tour_step_t  due_step;

    // Private copy of the weight store and of the node count register.
    logic [WEIGHT_BITS-1:0] edge_weight [MAX_NODES][MAX_NODES];
    logic [COUNT_BITS-1:0]  node_setting = COUNT_BITS'(MAX_NODES);
    logic [MAX_NODES:0]     sizes_run = '0;

    // The store as it will be once every queued word has gone in. Tours are planned
    // against it so that no tour reads an entry that was never written.
    logic [WEIGHT_BITS-1:0] plan_weight [MAX_NODES][MAX_NODES];
    bit   [MAX_NODES-1:0]   plan_written [MAX_NODES];

    int queued_words   = 0;
    int accepted_words = 0;
    int load_words     = 0;
    int tours_run      = 0;
    int results_seen   = 0;
    int failures       = 0;
    int cycle_count    = 0;
    int src_gap        = 0;
    int sink_gap       = 0;
    int src_idle_pct   = 30;
    int sink_idle_pct  = 10;
    bit calm           = 1'b0;

    nearest_neighbor_tour u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_op         (s_op),
        .s_row_node   (s_row_node),
        .s_col_node   (s_col_node),
        .s_weight     (s_weight),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_node       (m_node),
        .m_edge_cost  (m_edge_cost),
        .m_total_cost (m_total_cost),
        .m_last       (m_last)
    );

    always #(HALF_PERIOD) aclk = ~aclk;

    function automatic int clamp_nodes(input logic [COUNT_BITS-1:0] setting);
        if (setting < 2) return 2;
        if (setting > MAX_NODES) return MAX_NODES;
        return int'(setting);
    endfunction

    function automatic logic [TOTAL_BITS-1:0] add_saturating(
        input logic [TOTAL_BITS-1:0]  sum_in,
        input logic [WEIGHT_BITS-1:0] w
    );
        logic [TOTAL_BITS:0] wide;
        wide = (TOTAL_BITS + 1)'(sum_in) + (TOTAL_BITS + 1)'(w);
        if (wide[TOTAL_BITS]) return TOTAL_FULL;
        return wide[TOTAL_BITS-1:0];
    endfunction

    function automatic logic [WEIGHT_BITS-1:0] pick_weight(input weight_style_t style);
        case (style)
            W_TIES:     return WEIGHT_BITS'($urandom_range(0, 3));
            W_EXTREME:  return $urandom_range(0, 1) ? WEIGHT_FULL : '0;
            W_NEAR_TOP: return WEIGHT_FULL - WEIGHT_BITS'($urandom_range(0, 15));
            W_TOP:      return WEIGHT_FULL;
            default:    return WEIGHT_BITS'($urandom);
        endcase
    endfunction

    task automatic push_step(
        input int                     node,
        input logic [WEIGHT_BITS-1:0] cost,
        input logic [TOTAL_BITS-1:0]  total,
        input logic                   closing
    );
        tour_step_t step;
        step.node       = NODE_BITS'(node);
        step.edge_cost  = cost;
        step.total_cost = total;
        step.closing    = closing;
        tour_steps_due.insert(tour_steps_due.size(), step);
    endtask

    // Loads update the private store; a start walks the greedy tour from node zero.
    task automatic apply_word(input graph_word_t word);
        int                     n;
        int                     here;
        int                     best;
        int                     step;
        int                     cand;
        bit                     found;
        logic [MAX_NODES-1:0]   seen;
        logic [WEIGHT_BITS-1:0] best_w;
        logic [TOTAL_BITS-1:0]  total;
        if (word.op == nnt_pkg::OP_LOAD) begin
            edge_weight[word.row][word.col] = word.weight;
            load_words++;
            return;
        end
        n = clamp_nodes(node_setting);
        tours_run++;
        sizes_run[n] = 1'b1;
        here  = 0;
        total = '0;
        seen  = MAX_NODES'(1);
        push_step(0, '0, '0, 1'b0);
        for (step = 1; step < n; step++) begin
            found  = 1'b0;
            best   = 0;
            best_w = '0;
            // Strict less-than keeps the lowest index on a tie.
            for (cand = 0; cand < n; cand++) begin
                if (!seen[cand] && (!found || edge_weight[here][cand] < best_w)) begin
                    found  = 1'b1;
                    best   = cand;
                    best_w = edge_weight[here][cand];
                end
            end
            seen[best] = 1'b1;
            total      = add_saturating(total, best_w);
            here       = best;
            push_step(best, best_w, total, 1'b0);
        end
        best_w = edge_weight[here][0];
        total  = add_saturating(total, best_w);
        push_step(0, best_w, total, 1'b1);
    endtask

    task automatic send_word(
        input logic                   op,
        input int                     row,
        input int                     col,
        input logic [WEIGHT_BITS-1:0] w
    );
        graph_word_t word;
        word.op     = op;
        word.row    = NODE_BITS'(row);
        word.col    = NODE_BITS'(col);
        word.weight = w;
        if (op == nnt_pkg::OP_LOAD) begin
            plan_weight[word.row][word.col]  = w;
            plan_written[word.row][word.col] = 1'b1;
        end
        words_to_send.insert(words_to_send.size(), word);
        queued_words++;
    endtask

    // The row, column and weight of a start word carry no meaning, so they are random.
    task automatic send_start();
        send_word(nnt_pkg::OP_START, $urandom_range(0, MAX_NODES - 1),
                  $urandom_range(0, MAX_NODES - 1), WEIGHT_BITS'($urandom));
    endtask

    // Walks the tour ahead of time and loads every entry it will read that is still
    // unwritten, then sends the start word.
    task automatic plan_tour(input weight_style_t style);
        int                     n;
        int                     here;
        int                     best;
        int                     step;
        int                     cand;
        bit                     found;
        logic [MAX_NODES-1:0]   seen;
        logic [WEIGHT_BITS-1:0] best_w;
        n    = clamp_nodes(node_setting);
        here = 0;
        seen = MAX_NODES'(1);
        for (step = 1; step < n; step++) begin
            found  = 1'b0;
            best   = 0;
            best_w = '0;
            for (cand = 0; cand < n; cand++) begin
                if (!seen[cand]) begin
                    if (!plan_written[here][cand]) begin
                        send_word(nnt_pkg::OP_LOAD, here, cand, pick_weight(style));
                    end
                    if (!found || plan_weight[here][cand] < best_w) begin
                        found  = 1'b1;
                        best   = cand;
                        best_w = plan_weight[here][cand];
                    end
                end
            end
            seen[best] = 1'b1;
            here       = best;
        end
        if (!plan_written[here][0]) begin
            send_word(nnt_pkg::OP_LOAD, here, 0, pick_weight(style));
        end
        send_start();
    endtask

    // A trailing load may still be in flight after the last result, hence the settle time.
    task automatic wait_idle();
        while (accepted_words != queued_words || tour_steps_due.size() != 0) begin
            @(negedge aclk);
        end
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_node_count(input int value);
        wait_idle();
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= COUNT_BITS'(value);
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        @(negedge aclk);
        node_setting = COUNT_BITS'(value);
    endtask

    // Word driver: a new word is offered only once the previous one has been taken.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                apply_word({s_op, s_row_node, s_col_node, s_weight});
                accepted_words++;
            end
            if (!s_valid || s_ready) begin
                if (src_gap != 0) begin
                    src_gap--;
                    s_valid <= 1'b0;
                end else if (!calm && words_to_send.size() != 0
                             && $urandom_range(0, 99) < src_idle_pct) begin
                    src_gap = $urandom_range(0, 11);
                    s_valid <= 1'b0;
                end else if (words_to_send.size() != 0) begin
                    next_word = words_to_send.pop_front();
                    s_valid    <= 1'b1;
                    s_op       <= next_word.op;
                    s_row_node <= next_word.row;
                    s_col_node <= next_word.col;
                    s_weight   <= next_word.weight;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor with random back-pressure.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (tour_steps_due.size() == 0) begin
                    $error("unexpected result: node %0d, edge_cost %0d, total_cost %0d",
                           m_node, m_edge_cost, m_total_cost);
                    failures++;
                end else begin
                    due_step = tour_steps_due.pop_front();
                    if (m_node !== due_step.node) begin
                        $error("node: expected %0d, got %0d", due_step.node, m_node);
                        failures++;
                    end
                    if (m_edge_cost !== due_step.edge_cost) begin
                        $error("edge_cost: expected %0d, got %0d",
                               due_step.edge_cost, m_edge_cost);
                        failures++;
                    end
                    if (m_total_cost !== due_step.total_cost) begin
                        $error("total_cost: expected %0d, got %0d",
                               due_step.total_cost, m_total_cost);
                        failures++;
                    end
                    if (m_last !== due_step.closing) begin
                        $error("last: expected %0d, got %0d", due_step.closing, m_last);
                        failures++;
                    end
                end
            end
            if (sink_gap != 0) begin
                sink_gap--;
                m_ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 99) < sink_idle_pct) begin
                sink_gap = $urandom_range(0, 11);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Timed out after %0d cycles: %0d of %0d words taken, %0d results outstanding.",
                 cycle_count, accepted_words, queued_words, tour_steps_due.size());
        $display("nearest_neighbor_tour regression: fail");
        $finish;
    end

    initial begin
        int            value;
        int            phase_n;
        int            tours;
        int            loads;
        int            t;
        int            row;
        int            col;
        weight_style_t style;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Two nodes, with counts below the minimum raised to two.
        write_node_count(0);
        send_word(nnt_pkg::OP_LOAD, 0, 1, WEIGHT_FULL);
        send_word(nnt_pkg::OP_LOAD, 1, 0, WEIGHT_FULL);
        send_start();
        send_word(nnt_pkg::OP_LOAD, 0, 1, '0);
        send_word(nnt_pkg::OP_LOAD, 1, 0, '0);
        send_start();
        write_node_count(1);
        send_word(nnt_pkg::OP_LOAD, 1, 0, 16'h8001);
        send_start();

        // Three nodes with a tie out of node zero, which the lower index must win.
        write_node_count(3);
        send_word(nnt_pkg::OP_LOAD, 0, 1, 7);
        send_word(nnt_pkg::OP_LOAD, 0, 2, 7);
        send_word(nnt_pkg::OP_LOAD, 1, 0, 9);
        send_word(nnt_pkg::OP_LOAD, 1, 2, 3);
        send_word(nnt_pkg::OP_LOAD, 2, 0, 4);
        send_word(nnt_pkg::OP_LOAD, 2, 1, 3);
        send_start();
        send_word(nnt_pkg::OP_LOAD, MAX_NODES - 1, MAX_NODES - 1, 16'h5AA5);
        send_word(nnt_pkg::OP_LOAD, 0, 2, 6);
        send_start();

        // Random phases: each picks a node count and a weight style, then runs a few tours
        // with random loads in between.
        while (queued_words < ITEM_BUDGET) begin
            calm = (queued_words >= ITEM_BUDGET - CALM_TAIL);
            case ($urandom_range(0, 15))
                0, 1:    value = $urandom_range(0, 1);
                2, 3:    value = $urandom_range(11, BIG_NODES);
                default: value = $urandom_range(2, 10);
            endcase
            write_node_count(value);
            phase_n       = clamp_nodes(COUNT_BITS'(value));
            style         = weight_style_t'($urandom_range(W_RANDOM, W_TOP));
            src_idle_pct  = $urandom_range(0, 2) * 20;
            sink_idle_pct = $urandom_range(0, 2) * 8;
            tours         = $urandom_range(1, 3);
            for (t = 0; t < tours && queued_words < ITEM_BUDGET; t++) begin
                loads = $urandom_range(0, 2 * phase_n);
                repeat (loads) begin
                    // Most loads land inside the tour, a few anywhere in the store.
                    if ($urandom_range(0, 9) == 0) begin
                        row = $urandom_range(0, MAX_NODES - 1);
                        col = $urandom_range(0, MAX_NODES - 1);
                    end else begin
                        row = $urandom_range(0, phase_n - 1);
                        col = $urandom_range(0, phase_n - 1);
                    end
                    send_word(nnt_pkg::OP_LOAD, row, col, pick_weight(style));
                end
                plan_tour(style);
            end
        end

        calm = 1'b1;
        wait_idle();
        repeat (END_CYCLES) @(negedge aclk);

        $display("Covered %0d load words and %0d tours over %0d distinct node counts.",
                 load_words, tours_run, $countones(sizes_run));
        $display("Compared %0d tour results in %0d cycles.", results_seen, cycle_count);
        if (failures == 0) begin
            $display("nearest_neighbor_tour regression: pass");
        end else begin
            $display("nearest_neighbor_tour regression: fail");
        end
        $finish;
    end

endmodule

// ===== nearest_neighbor_tour.f =====
+incdir+hw/rtl
hw/rtl/nnt_pkg.sv
hw/rtl/nnt_ctrl.sv
hw/rtl/nnt_datapath.sv
hw/rtl/nearest_neighbor_tour.sv
hw/rtl/nnt_checker.sv
sim/tb.sv
